>>> hw/rtl/wdt_pkg.sv
`timescale 1ns / 1ps
package wdt_pkg;
	localparam int SLOTS_DEF      = 64;
	localparam int ARCH_COUNT_DEF = 16;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_VERIFY   = 3'd2,
		OP_FIND     = 3'd3,
		OP_ASSIGN   = 3'd4,
		OP_RELEASE  = 3'd5,
		OP_DISPATCH = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_VERIFY = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [31:0] chk;
		logic [31:0] tok;
		logic [3:0]  arch;
		logic [3:0]  host;
		logic        xc;
		logic [15:0] cost;
	} entry_t;
endpackage

>>> hw/rtl/wdt_req_if.sv
`timescale 1ns / 1ps
interface wdt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [5:0]  slot;
	logic [15:0] remote_addr;
	logic [31:0] check;
	logic [31:0] token;
	logic [3:0]  arch;
	logic [3:0]  host_arch;
	logic        is_cross;
	logic [15:0] cost;
	logic        cross_ok;

	modport source (output valid, opcode, slot, remote_addr, check, token, arch, host_arch,
		is_cross, cost, cross_ok, input ready);
	modport sink (input valid, opcode, slot, remote_addr, check, token, arch, host_arch,
		is_cross, cost, cross_ok, output ready);
endinterface

>>> hw/rtl/wdt_rsp_if.sv
`timescale 1ns / 1ps
interface wdt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  slot_out;
	logic [15:0] chosen_cost;

	modport source (output valid, status, slot_out, chosen_cost, input ready);
	modport sink (input valid, status, slot_out, chosen_cost, output ready);
endinterface

>>> hw/rtl/worker_dispatch_table_top.sv
`timescale 1ns / 1ps
// Remove, assign, release and unused opcodes: result set at the transfer, then the done state and the output register.
// Verify: one read of the slot memory, checked in the verify state, then the done state and the output register.
// Insert, find and dispatch: one read per slot in the scan state, then the done state and the output register.
// One item at a time; the next transfer is taken once the result sits in the output register,
// so a result that waits for ready holds off the next transfer.
// Reset clears the valid and busy flags at once; slot memory contents stay undefined.
module worker_dispatch_table_top #(
	parameter int SLOTS      = wdt_pkg::SLOTS_DEF,
	parameter int ARCH_COUNT = wdt_pkg::ARCH_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	wdt_req_if.sink    req,
	wdt_rsp_if.source  rsp
);
	import wdt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	state_t          state_q;
	opcode_t         op_q;
	logic [15:0]     addr_q;
	logic [31:0]     chk_q;
	logic [31:0]     tok_q;
	logic [3:0]      arch_q;
	logic [3:0]      host_q;
	logic            xc_q;
	logic [15:0]     cost_q;
	logic            canx_q;
	logic            sv_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] busy_q;
	entry_t          mem [SLOTS];
	entry_t          rdata_q;
	logic [CW-1:0]   cnt_q;
	logic            s1_q;
	logic [IW-1:0]   idx_s1;
	logic            v_s1;
	logic            b_s1;
	logic            have_q;
	logic [IW-1:0]   best_q;
	logic [15:0]     bcost_q;
	status_t         res_status_q;
	logic [5:0]      res_slot_q;
	logic [15:0]     res_cost_q;
	logic            ov_q;
	status_t         os_q;
	logic [5:0]      oslot_q;
	logic [15:0]     ocost_q;

	logic            acc;
	logic            sv_in;
	logic            issue;
	logic [IW-1:0]   raddr;
	logic            arch_ok;
	logic            hit;
	logic            take;
	logic            have_n;
	logic [IW-1:0]   best_n;
	logic [15:0]     bcost_n;
	logic            last;
	logic            we;
	logic            out_load;

	assign req.ready       = (state_q == S_IDLE);
	assign acc             = req.valid && req.ready;
	assign sv_in           = (32'(req.slot) < SLOTS) && valid_q[IW'(req.slot)];
	assign issue           = (state_q == S_SCAN) && (cnt_q < CW'(SLOTS));
	assign raddr           = (state_q == S_IDLE) ? IW'(req.slot) : cnt_q[IW-1:0];
	assign arch_ok         = 32'(arch_q) < ARCH_COUNT;
	assign out_load        = (state_q == S_DONE) && (!ov_q || rsp.ready);

	always_comb begin
		unique case (op_q)
			OP_INSERT:   hit = s1_q && !v_s1;
			OP_FIND:     hit = s1_q && v_s1 && (rdata_q.addr == addr_q) &&
				(rdata_q.tok == tok_q);
			OP_DISPATCH: hit = s1_q && v_s1 && !b_s1 && arch_ok && (rdata_q.arch == arch_q) &&
				(!rdata_q.xc || canx_q);
			default:     hit = 1'b0;
		endcase
	end

	assign take    = hit && (!have_q || ((op_q == OP_DISPATCH) && (rdata_q.cost < bcost_q)));
	assign have_n  = have_q || take;
	assign best_n  = take ? idx_s1 : best_q;
	assign bcost_n = take ? rdata_q.cost : bcost_q;
	assign last    = s1_q && (idx_s1 == IW'(SLOTS - 1));
	assign we      = (state_q == S_SCAN) && last && (op_q == OP_INSERT) && have_n;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[best_n] <= '{addr: addr_q, chk: chk_q, tok: tok_q, arch: arch_q,
				host: host_q, xc: xc_q, cost: cost_q};
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			busy_q  <= '0;
			cnt_q   <= '0;
			s1_q    <= 1'b0;
			have_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q  <= '0;
					s1_q   <= 1'b0;
					have_q <= 1'b0;
					if (acc) begin
						case (opcode_t'(req.opcode))
							OP_INSERT, OP_FIND, OP_DISPATCH: state_q <= S_SCAN;
							OP_VERIFY: state_q <= S_VERIFY;
							OP_REMOVE: begin
								if (sv_in) begin
									valid_q[IW'(req.slot)] <= 1'b0;
									busy_q[IW'(req.slot)]  <= 1'b0;
								end
								state_q <= S_DONE;
							end
							OP_ASSIGN: begin
								if (sv_in && (32'(req.arch) < ARCH_COUNT))
									busy_q[IW'(req.slot)] <= 1'b1;
								state_q <= S_DONE;
							end
							OP_RELEASE: begin
								if (sv_in)
									busy_q[IW'(req.slot)] <= 1'b0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					cnt_q  <= cnt_q + CW'(issue);
					s1_q   <= issue;
					have_q <= have_n;
					if (last)
						state_q <= S_DONE;
					if (we) begin
						valid_q[best_n] <= 1'b1;
						busy_q[best_n]  <= 1'b0;
					end
				end
				S_VERIFY: state_q <= S_DONE;
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_load)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= opcode_t'(req.opcode);
			addr_q <= req.remote_addr;
			chk_q  <= req.check;
			tok_q  <= req.token;
			arch_q <= req.arch;
			host_q <= req.host_arch;
			xc_q   <= req.is_cross;
			cost_q <= req.cost;
			canx_q <= req.cross_ok;
			sv_q   <= sv_in;
			res_cost_q <= '0;
			case (opcode_t'(req.opcode))
				OP_REMOVE, OP_RELEASE, OP_VERIFY: begin
					res_status_q <= sv_in ? ST_OK : ST_NONE;
					res_slot_q   <= req.slot;
				end
				OP_ASSIGN: begin
					res_status_q <= (sv_in && (32'(req.arch) < ARCH_COUNT)) ? ST_OK : ST_NONE;
					res_slot_q   <= req.slot;
				end
				default: begin
					res_status_q <= ST_NONE;
					res_slot_q   <= '0;
				end
			endcase
		end
		if (state_q == S_SCAN) begin
			idx_s1  <= cnt_q[IW-1:0];
			v_s1    <= valid_q[cnt_q[IW-1:0]];
			b_s1    <= busy_q[cnt_q[IW-1:0]];
			best_q  <= best_n;
			bcost_q <= bcost_n;
			if (last) begin
				res_slot_q <= have_n ? 6'(best_n) : '0;
				res_cost_q <= '0;
				priority case (op_q)
					OP_INSERT: res_status_q <= have_n ? ST_OK : ST_FULL;
					OP_DISPATCH: begin
						res_status_q <= have_n ? ST_OK : ST_NONE;
						res_cost_q   <= have_n ? bcost_n : '0;
					end
					default: res_status_q <= have_n ? ST_OK : ST_NONE;
				endcase
			end
		end
		if (state_q == S_VERIFY)
			res_status_q <= (sv_q && (rdata_q.chk == chk_q)) ? ST_OK : ST_NONE;
		if (out_load) begin
			os_q    <= res_status_q;
			oslot_q <= res_slot_q;
			ocost_q <= res_cost_q;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = os_q;
	assign rsp.slot_out    = oslot_q;
	assign rsp.chosen_cost = ocost_q;

	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != S_IDLE)
		else $error("accepted item did not start");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && last |=> state_q == S_DONE)
		else $error("scan did not finish");
	a_cost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (os_q != ST_OK) |-> ocost_q == '0)
		else $error("cost on failed result");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SLOTS))
		else $error("scan counter overrun");
endmodule

>>> tb/worker_dispatch_table_top_tb.sv
`timescale 1ns / 1ps
module worker_dispatch_table_top_tb;
	import wdt_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam int NARCH = ARCH_COUNT_DEF;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_out;
		logic [15:0] chosen_cost;
	} reply_t;

	logic clk;
	logic arst_n;
	wdt_req_if req ();
	wdt_rsp_if rsp ();

	worker_dispatch_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	bit          tbl_valid [NSLOT];
	logic [15:0] tbl_addr [NSLOT];
	logic [31:0] tbl_check [NSLOT];
	logic [31:0] tbl_token [NSLOT];
	logic [3:0]  tbl_arch [NSLOT];
	bit          tbl_cross [NSLOT];
	logic [15:0] tbl_cost [NSLOT];
	bit          tbl_busy [NSLOT];

	reply_t pending_replies[$];
	int     errors;
	int     idle_cycles;
	bit     quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic reply_t predict_reply(logic [2:0] op, logic [5:0] s, logic [15:0] addr,
		logic [31:0] chk, logic [31:0] tok, logic [3:0] ar, logic xc, logic [15:0] cst,
		logic canx);
		reply_t r;
		bit have;
		int best;
		r = '{status: ST_NONE, slot_out: 6'd0, chosen_cost: 16'd0};
		have = 1'b0;
		best = 0;
		case (op)
			OP_INSERT: begin
				r.status = ST_FULL;
				for (int i = 0; i < NSLOT; i++) begin
					if (!tbl_valid[i]) begin
						tbl_valid[i] = 1'b1;
						tbl_addr[i] = addr;
						tbl_check[i] = chk;
						tbl_token[i] = tok;
						tbl_arch[i] = ar;
						tbl_cross[i] = xc;
						tbl_cost[i] = cst;
						tbl_busy[i] = 1'b0;
						r.status = ST_OK;
						r.slot_out = 6'(i);
						break;
					end
				end
			end
			OP_REMOVE, OP_RELEASE: begin
				r.slot_out = s;
				if (tbl_valid[s]) begin
					if (op == OP_REMOVE) tbl_valid[s] = 1'b0;
					tbl_busy[s] = 1'b0;
					r.status = ST_OK;
				end
			end
			OP_VERIFY: begin
				r.slot_out = s;
				if (tbl_valid[s] && tbl_check[s] == chk) r.status = ST_OK;
			end
			OP_FIND: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_valid[i] && tbl_addr[i] == addr && tbl_token[i] == tok) begin
						r.status = ST_OK;
						r.slot_out = 6'(i);
						break;
					end
				end
			end
			OP_ASSIGN: begin
				r.slot_out = s;
				if (tbl_valid[s] && ar < NARCH) begin
					tbl_busy[s] = 1'b1;
					r.status = ST_OK;
				end
			end
			OP_DISPATCH: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_valid[i] && !tbl_busy[i] && tbl_arch[i] == ar
						&& !(tbl_cross[i] && !canx)
						&& (!have || tbl_cost[i] < tbl_cost[best])) begin
						have = 1'b1;
						best = i;
					end
				end
				if (have) begin
					r.status = ST_OK;
					r.slot_out = 6'(best);
					r.chosen_cost = tbl_cost[best];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic hold_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 7);
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(logic [2:0] op, logic [5:0] s, logic [15:0] addr, logic [31:0] chk,
		logic [31:0] tok, logic [3:0] ar, logic [3:0] har, logic xc, logic [15:0] cst,
		logic canx);
		hold_gap();
		req.valid <= 1'b1;
		req.opcode <= op;
		req.slot <= s;
		req.remote_addr <= addr;
		req.check <= chk;
		req.token <= tok;
		req.arch <= ar;
		req.host_arch <= har;
		req.is_cross <= xc;
		req.cost <= cst;
		req.cross_ok <= canx;
		do @(posedge clk); while (!req.ready);
		pending_replies.push_back(predict_reply(op, s, addr, chk, tok, ar, xc, cst, canx));
	endtask

	task automatic send_random(int op_sel);
		logic [2:0] op;
		int s;
		s = $urandom_range(0, NSLOT - 1);
		for (int k = 0; k < 4 && !tbl_valid[s]; k++) s = $urandom_range(0, NSLOT - 1);
		op = op_sel < 0 ? 3'($urandom_range(0, 7)) : 3'(op_sel);
		send_item(op, 6'(s), 16'($urandom_range(0, 3)),
			$urandom_range(0, 1) ? tbl_check[s] : $urandom(),
			$urandom_range(0, 1) ? tbl_token[s] : $urandom(), 4'($urandom_range(0, 3)),
			4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom_range(0, 1) ?
			16'($urandom_range(0, 7)) : 16'($urandom()), 1'($urandom_range(0, 1)));
	endtask

	task automatic drain_replies();
		req.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic test_fill_table();
		send_item(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		send_item(OP_FIND, 0, 16'hFFFE, '1, '1, 0, 0, 0, 0, 0);
		send_item(OP_REMOVE, 63, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < NSLOT; i++)
			send_item(OP_INSERT, 6'd0, i == 0 ? 16'hFFFE : 16'(i), i == 1 ? '1 : $urandom(),
				i == 2 ? '1 : 32'(i), 4'(i % 16), 4'(15 - i % 16), i[0],
				i == 3 ? 16'hFFFF : 16'(i % 5), 1'b0);
		send_item(OP_INSERT, 0, 1, 1, 1, 1, 1, 1, 1, 1);
	endtask

	task automatic test_slot_ops();
		send_item(OP_VERIFY, 1, 0, '1, 0, 0, 0, 0, 0, 0);
		send_item(OP_VERIFY, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_FIND, 0, 16'hFFFE, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_FIND, 0, 2, 0, '1, 0, 0, 0, 0, 0);
		send_item(OP_ASSIGN, 63, 0, 0, 0, 4'hF, 0, 0, 0, 0);
		send_item(OP_ASSIGN, 63, 0, 0, 0, 4'h3, 0, 0, 0, 0);
		send_item(OP_RELEASE, 63, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_RELEASE, 63, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_DISPATCH, 0, 0, 0, 0, 4'hF, 0, 0, 0, 0);
		send_item(OP_DISPATCH, 0, 0, 0, 0, 4'hF, 0, 0, 0, 1);
		send_item(OP_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(OP_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		drain_replies();
		for (int i = 0; i < NSLOT; i++) send_item(OP_REMOVE, 6'(i), 0, 0, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 560; n++) begin
			if (n == 280) drain_replies();
			if (n >= 460) quiet = 1'b1;
			send_random($urandom_range(0, 9) < 3 ? OP_INSERT : -1);
		end
	endtask

	task automatic test_dispatch_ties();
		for (int n = 0; n < 60; n++) send_random($urandom_range(0, 1) ? OP_DISPATCH : OP_INSERT);
	endtask

	initial begin
		errors = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = '0;
		req.slot = '0;
		req.remote_addr = '0;
		req.check = '0;
		req.token = '0;
		req.arch = '0;
		req.host_arch = '0;
		req.is_cross = 1'b0;
		req.cost = '0;
		req.cross_ok = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_busy[i] = 1'b0;
			tbl_addr[i] = '0;
			tbl_check[i] = '0;
			tbl_token[i] = '0;
			tbl_arch[i] = '0;
			tbl_cross[i] = 1'b0;
			tbl_cost[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_table();
		test_slot_ops();
		test_random_mix();
		test_dispatch_ties();
		drain_replies();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{status: rsp.status, slot_out: rsp.slot_out, chosen_cost: rsp.chosen_cost};
			if (pending_replies.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %p", $time, got);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status: expected %0d, actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.slot_out !== want.slot_out) begin
					$display("%0t slot_out: expected %0d, actual %0d", $time, want.slot_out,
						got.slot_out);
					errors++;
				end
				if (got.chosen_cost !== want.chosen_cost) begin
					$display("%0t chosen_cost: expected %0d, actual %0d", $time,
						want.chosen_cost, got.chosen_cost);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end
endmodule

>>> filelist.f
hw/rtl/wdt_pkg.sv
hw/rtl/wdt_req_if.sv
hw/rtl/wdt_rsp_if.sv
hw/rtl/worker_dispatch_table_top.sv
tb/worker_dispatch_table_top_tb.sv
